/* design/dgsp_pkg.sv */
// Shared types and constants for the dense-graph shortest-path block.
package dgsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VID_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VID_W + 1;
    localparam int DIST_W       = 10;
    localparam int SUM_W        = DIST_W + 1;
    localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W       = 2 * VID_W;
    localparam int VCNT_W       = 5;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(MAX_VERTICES);
    localparam logic [DIST_W-1:0] LIMIT_RESET  = DIST_W'(999);
    localparam logic [CNT_W-1:0]  MIN_COUNT    = CNT_W'(2);
    localparam logic [CNT_W-1:0]  MAX_COUNT    = CNT_W'(MAX_VERTICES);

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_UNREACH_LIM  = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic
    {
        ALU_SELECT,
        ALU_RELAX
    } alu_op_t;

endpackage

/* design/dgsp_alu.sv */
// Shared add and compare unit used by both the select scan and the relax sweep.
module dgsp_alu
    import dgsp_pkg::*;
(
    input  alu_op_t           op,
    input  logic [DIST_W-1:0] lhs,
    input  logic [DIST_W-1:0] add_a,
    input  logic [DIST_W-1:0] add_b,
    output logic [SUM_W-1:0]  sum,
    output logic              le
);

    logic [SUM_W-1:0] rhs;

    assign sum = {1'b0, add_a} + {1'b0, add_b};

    // Select: distance against best so far. Relax: distance against path sum.
    always_comb
    begin
        case (op)
            ALU_SELECT: rhs = {1'b0, add_a};
            ALU_RELAX:  rhs = sum;
            default:    rhs = {1'b0, add_a};
        endcase
    end

    assign le = ({1'b0, lhs} <= rhs);

endmodule

/* design/dense_graph_shortest_path.sv */
// Top level: cost matrix memory, distance registers and the run sequencer.
// Load: writes one matrix entry, busy stays low. Run: seed the distances from the
// source row, then for each of n-2 passes a select scan plus a relax sweep over the
// selected row, then n results; the run length is set by the one-entry-per-cycle
// matrix read port and the single shared compare unit.
// Results leave one per cycle on a one-cycle valid strobe; the receiver cannot stall.
// Reset clears control, configuration, distances and flags; the matrix is not cleared.
module dense_graph_shortest_path
    import dgsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [VID_W-1:0]  row,
    input  logic [VID_W-1:0]  col,
    input  logic [DIST_W-1:0] weight,
    input  logic [VID_W-1:0]  source,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [DIST_W-1:0] cfg_data,
    output logic              valid,
    output logic [VID_W-1:0]  vertex,
    output logic [DIST_W-1:0] distance,
    output logic              last
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_INIT,
        ST_SEL,
        ST_RELAX,
        ST_OUT
    } state_t;

    // Control
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       pass_reg, pass_next;
    logic [VID_W-1:0]       src_reg, src_next;
    logic [VID_W-1:0]       u_reg, u_next;
    logic [DIST_W-1:0]      best_reg, best_next;
    logic                   found_reg, found_next;
    logic                   pend_reg, pend_next;
    logic [VID_W-1:0]       pidx_reg, pidx_next;

    // Configuration
    logic [VCNT_W-1:0]      vcount_reg, vcount_next;
    logic [DIST_W-1:0]      limit_reg, limit_next;

    // Distances and selected flags
    logic [DIST_W-1:0]      dist_reg [MAX_VERTICES];
    logic [DIST_W-1:0]      dist_next [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] sel_reg, sel_next;

    // Result registers
    logic                   valid_reg, valid_next;
    logic [VID_W-1:0]       vertex_reg, vertex_next;
    logic [DIST_W-1:0]      distance_reg, distance_next;
    logic                   last_reg, last_next;

    // Cost matrix
    logic [DIST_W-1:0]      mem [MEM_DEPTH];
    logic [DIST_W-1:0]      rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [ADDR_W-1:0]      mem_raddr;

    // Datapath
    logic [VID_W-1:0]       cidx;
    logic [VID_W-1:0]       rd_idx;
    logic [DIST_W-1:0]      rd_dist;
    logic [CNT_W-1:0]       n_eff;
    logic                   accept;
    alu_op_t                alu_op;
    logic [SUM_W-1:0]       alu_sum;
    logic                   alu_le;
    logic                   cand;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign valid     = valid_reg;
    assign vertex    = vertex_reg;
    assign distance  = distance_reg;
    assign last      = last_reg;

    assign cidx   = cnt_reg[VID_W-1:0];
    assign rd_idx = (state_reg == ST_RELAX) ? pidx_reg : cidx;
    assign rd_dist = dist_reg[rd_idx];

    // Clamp the vertex count into the supported range
    always_comb
    begin
        if ({1'b0, vcount_reg} < {1'b0, MIN_COUNT})
            n_eff = MIN_COUNT;
        else if ({1'b0, vcount_reg} > {1'b0, MAX_COUNT})
            n_eff = MAX_COUNT;
        else
            n_eff = CNT_W'(vcount_reg);
    end

    assign alu_op = (state_reg == ST_RELAX) ? ALU_RELAX : ALU_SELECT;

    dgsp_alu u_alu
    (
        .op    (alu_op),
        .lhs   (rd_dist),
        .add_a (best_reg),
        .add_b (rdata_reg),
        .sum   (alu_sum),
        .le    (alu_le)
    );

    assign cand = !sel_reg[cidx] && alu_le;

    // Matrix ports: loads write while idle, the sequencer reads one entry per cycle
    assign mem_we    = accept && (opcode == OP_LOAD);
    assign mem_waddr = {row, col};
    assign mem_raddr = {(state_reg == ST_INIT) ? src_reg : u_reg, cidx};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= weight;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        pass_next     = pass_reg;
        src_next      = src_reg;
        u_next        = u_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        vcount_next   = vcount_reg;
        limit_next    = limit_reg;
        dist_next     = dist_reg;
        sel_next      = sel_reg;
        valid_next    = 1'b0;
        vertex_next   = vertex_reg;
        distance_next = distance_reg;
        last_next     = 1'b0;

        // Configuration transfer
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: vcount_next = cfg_data[VCNT_W-1:0];
                CFG_UNREACH_LIM:  limit_next  = cfg_data;
                default:          limit_next  = limit_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Drop runs whose source lies outside the vertices in use
                if (accept && (opcode == OP_RUN) && ({1'b0, source} < n_eff))
                begin
                    n_next          = n_eff;
                    src_next        = source;
                    pass_next       = n_eff - MIN_COUNT;
                    sel_next        = '0;
                    sel_next[source] = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_INIT;
                end
            end

            ST_INIT, ST_RELAX:
            begin
                // Issue one row read per cycle; handle its data in the next cycle
                if (cnt_reg < n_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = cidx;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (state_reg == ST_INIT)
                        dist_next[pidx_reg] = rdata_reg;
                    else if (!sel_reg[pidx_reg] && !alu_le)
                        dist_next[pidx_reg] = alu_sum[DIST_W-1:0];
                end
                else if (cnt_reg == n_reg)
                begin
                    cnt_next   = '0;
                    best_next  = limit_reg;
                    found_next = 1'b0;
                    if (state_reg == ST_RELAX)
                        pass_next = pass_reg - CNT_W'(1);
                    if ((state_reg == ST_INIT && pass_reg == '0) ||
                        (state_reg == ST_RELAX && pass_reg == CNT_W'(1)))
                        state_next = ST_OUT;
                    else
                        state_next = ST_SEL;
                end
            end

            ST_SEL:
            begin
                // Highest index wins ties because the scan runs upwards with <=
                if (cand)
                begin
                    best_next = rd_dist;
                    u_next    = cidx;
                end
                found_next = found_reg || cand;
                if (cnt_reg == n_reg - CNT_W'(1))
                begin
                    cnt_next = '0;
                    if (found_reg || cand)
                    begin
                        sel_next[cand ? cidx : u_reg] = 1'b1;
                        state_next = ST_RELAX;
                    end
                    else
                    begin
                        // No candidate: skip this pass
                        pass_next  = pass_reg - CNT_W'(1);
                        best_next  = limit_reg;
                        found_next = 1'b0;
                        if (pass_reg == CNT_W'(1))
                            state_next = ST_OUT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_OUT:
            begin
                valid_next    = 1'b1;
                vertex_next   = cidx;
                distance_next = rd_dist;
                if (cnt_reg == n_reg - CNT_W'(1))
                begin
                    last_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            n_reg      <= MIN_COUNT;
            pass_reg   <= '0;
            src_reg    <= '0;
            u_reg      <= '0;
            best_reg   <= '0;
            found_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
            vcount_reg <= VCOUNT_RESET;
            limit_reg  <= LIMIT_RESET;
            for (int i = 0; i < MAX_VERTICES; i++)
                dist_reg[i] <= '0;
            sel_reg    <= '0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            pass_reg   <= pass_next;
            src_reg    <= src_next;
            u_reg      <= u_next;
            best_reg   <= best_next;
            found_reg  <= found_next;
            pend_reg   <= pend_next;
            pidx_reg   <= pidx_next;
            vcount_reg <= vcount_next;
            limit_reg  <= limit_next;
            dist_reg   <= dist_next;
            sel_reg    <= sel_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
        end
    end

    // Result payload holds between strobes and needs no reset
    always_ff @(posedge clk)
    begin
        vertex_reg   <= vertex_next;
        distance_reg <= distance_next;
    end

endmodule

/* tb/tb_dense_graph_shortest_path.sv */
// Self-checking testbench for the dense-graph shortest-path block.
`timescale 1ns / 1ps

module tb_dense_graph_shortest_path;
    import dgsp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 270;
    localparam int PHASES        = 10;
    localparam int MAX_GAP       = 11;
    // Longest quiet stretch of a correct run: a full-size run plus the settle hold
    // and the longest sender gap, taken several times over.
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 600;
    localparam int MAX_PRINTED   = 100;

    typedef struct {
        logic [VID_W-1:0]  vertex;
        logic [DIST_W-1:0] distance;
        logic              last;
    } path_result_t;

    // Scoreboard: shadow copy of the matrix, distances and flags, plus the queue of
    // distance reports that the block still owes.
    class dgsp_scoreboard;
        logic [DIST_W-1:0] cost [MAX_VERTICES][MAX_VERTICES];
        bit                loaded [MAX_VERTICES][MAX_VERTICES];
        logic [DIST_W-1:0] path_len [MAX_VERTICES];
        bit                settled [MAX_VERTICES];
        logic [VCNT_W-1:0] vertex_count;
        logic [DIST_W-1:0] unreach_limit;
        path_result_t      expected_paths[$];
        int                errors;

        function new();
            vertex_count  = VCOUNT_RESET;
            unreach_limit = LIMIT_RESET;
            errors        = 0;
            foreach (path_len[i])
            begin
                path_len[i] = '0;
                settled[i]  = 1'b0;
            end
        endfunction

        function int active_vertices();
            int n;
            n = vertex_count;
            if (n < MIN_COUNT)
                n = MIN_COUNT;
            if (n > MAX_COUNT)
                n = MAX_COUNT;
            return n;
        endfunction

        function void write_register(logic idx, logic [DIST_W-1:0] data);
            if (idx == CFG_VERTEX_COUNT)
                vertex_count = data[VCNT_W-1:0];
            else
                unreach_limit = data;
        endfunction

        // Nearest unsettled vertex within the limit; later indices win ties.
        function int pick_nearest(int n);
            int                chosen;
            logic [DIST_W-1:0] best;
            chosen = -1;
            best   = unreach_limit;
            for (int i = 0; i < n; i++)
            begin
                if (!settled[i] && path_len[i] <= best)
                begin
                    best   = path_len[i];
                    chosen = i;
                end
            end
            return chosen;
        endfunction

        function void solve_paths(int src);
            int                n;
            int                u;
            logic [SUM_W-1:0]  sum;
            path_result_t      res;
            n = active_vertices();
            for (int i = 0; i < n; i++)
            begin
                settled[i]  = 1'b0;
                path_len[i] = cost[src][i];
            end
            settled[src] = 1'b1;
            for (int p = 2; p < n; p++)
            begin
                u = pick_nearest(n);
                if (u >= 0)
                begin
                    settled[u] = 1'b1;
                    for (int w = 0; w < n; w++)
                    begin
                        sum = {1'b0, path_len[u]} + {1'b0, cost[u][w]};
                        if (!settled[w] && {1'b0, path_len[w]} > sum)
                            path_len[w] = sum[DIST_W-1:0];
                    end
                end
            end
            for (int i = 0; i < n; i++)
            begin
                res.vertex   = VID_W'(i);
                res.distance = path_len[i];
                res.last     = (i == n - 1);
                expected_paths.push_back(res);
            end
        endfunction

        function void note_item(logic op, logic [VID_W-1:0] r, logic [VID_W-1:0] c,
                                logic [DIST_W-1:0] w, logic [VID_W-1:0] s);
            if (op == OP_LOAD)
            begin
                cost[r][c]   = w;
                loaded[r][c] = 1'b1;
            end
            else if (s < active_vertices())
                solve_paths(s);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [VID_W-1:0] v, logic [DIST_W-1:0] d, logic l);
            path_result_t want;
            if (expected_paths.size() == 0)
                report_mismatch($sformatf("unexpected result vertex %0d distance %0d last %0b",
                                          v, d, l));
            else
            begin
                want = expected_paths.pop_front();
                if (v !== want.vertex || d !== want.distance || l !== want.last)
                    report_mismatch($sformatf(
                        "got vertex %0d distance %0d last %0b, want %0d %0d %0b",
                        v, d, l, want.vertex, want.distance, want.last));
            end
        endtask

        function int pending();
            return expected_paths.size();
        endfunction
    endclass

    // Every input starts at a known value; all later changes are nonblocking at posedge.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              opcode    = OP_LOAD;
    logic [VID_W-1:0]  row       = '0;
    logic [VID_W-1:0]  col       = '0;
    logic [DIST_W-1:0] weight    = '0;
    logic [VID_W-1:0]  source    = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_index = CFG_VERTEX_COUNT;
    logic [DIST_W-1:0] cfg_data  = '0;
    logic              busy;
    logic              cfg_ready;
    logic              valid;
    logic [VID_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic              last;

    dgsp_scoreboard sb;
    bit             steady_sender;

    dense_graph_shortest_path u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .row       (row),
        .col       (col),
        .weight    (weight),
        .source    (source),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .valid     (valid),
        .vertex    (vertex),
        .distance  (distance),
        .last      (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Check every strobed result against the oldest expected distance report;
    // the receiver never stalls, so each strobe is one transfer.
    always @(posedge clk)
    begin
        if (rst_n && valid)
            sb.check_result(vertex, distance, last);
    end

    // Watchdog: end the run when nothing transfers for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || valid || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TIMEOUT: no transfer in %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Sender gap for the next item; none at all while the sender runs steady.
    function automatic int draw_gap();
        if (steady_sender)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Mix of tiny weights (many ties), the no-edge sentinel and the extremes.
    function automatic logic [DIST_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return DIST_W'($urandom_range(0, 7));
            1:       return DIST_W'($urandom_range(0, 40));
            2:       return sb.unreach_limit;
            3:       return '1;
            4:       return '0;
            default: return DIST_W'($urandom);
        endcase
    endfunction

    // Present one item, hold it until the transfer, then note it and idle for the gap.
    // With no gap start stays high, so the next item follows in the same step.
    task automatic send_item(logic op, logic [VID_W-1:0] r, logic [VID_W-1:0] c,
                             logic [DIST_W-1:0] w, logic [VID_W-1:0] s, int gap);
        start  <= 1'b1;
        opcode <= op;
        row    <= r;
        col    <= c;
        weight <= w;
        source <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(op, r, c, w, s);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Unused fields carry random bits; the block must ignore them.
    task automatic send_load(int r, int c, logic [DIST_W-1:0] w);
        send_item(OP_LOAD, VID_W'(r), VID_W'(c), w, VID_W'($urandom_range(0, 15)),
                  draw_gap());
    endtask

    task automatic send_run(int s);
        send_item(OP_RUN, VID_W'($urandom_range(0, 15)), VID_W'($urandom_range(0, 15)),
                  DIST_W'($urandom), VID_W'(s), draw_gap());
    endtask

    // Hold off the sender until every owed result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Drain, then let a trailing load finish before touching the registers.
    task automatic settle_idle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high across the two transfers.
    task automatic configure(int count_value, int limit_value);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_data  <= DIST_W'(count_value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(CFG_VERTEX_COUNT, DIST_W'(count_value));
        cfg_index <= CFG_UNREACH_LIM;
        cfg_data  <= DIST_W'(limit_value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(CFG_UNREACH_LIM, DIST_W'(limit_value));
        cfg_valid <= 1'b0;
    endtask

    // Load every entry of the active block that was never written, so that no run
    // reads an undefined cost.
    task automatic fill_block(int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!sb.loaded[r][c])
                    send_load(r, c, pick_weight());
    endtask

    int phase_count [PHASES] = '{16, 2, 31, 1, 17, 5, 16, 0, 8, 16};
    int phase_limit [PHASES] = '{999, 1023, 0, 999, 1023, 50, -1, 999, -1, 999};

    initial
    begin
        int n;
        int src;
        int done_items;
        int limit_value;

        sb = new();
        steady_sender = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: three vertices, extremes of weight, no-edge and full-range costs.
        configure(3, 999);
        send_load(0, 0, 0);
        send_load(0, 1, 1023);
        send_load(0, 2, 5);
        send_load(1, 0, 7);
        send_load(1, 1, 0);
        send_load(1, 2, 999);
        send_load(2, 0, 3);
        send_load(2, 1, 2);
        send_load(2, 2, 1023);
        send_run(0);
        send_run(1);
        send_run(2);
        // Sources at or above the vertex count: ignored, no results.
        send_run(3);
        send_run(15);

        // Limit of zero: no pass finds a candidate.
        settle_idle();
        configure(3, 0);
        send_run(0);

        // Top limit: a vertex at 1023 is selectable; equal distances test the tie rule,
        // and relaxing through 1023 forms a sum above ten bits.
        settle_idle();
        configure(3, 1023);
        send_load(0, 1, 5);
        send_load(0, 2, 5);
        send_run(0);
        send_run(1);

        // Count of zero acts as two.
        settle_idle();
        configure(0, 999);
        send_run(1);
        send_run(2);

        // Random phases: mostly runs over the loaded block, some loads reshaping it.
        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            limit_value = (phase_limit[p] < 0) ? $urandom_range(0, 1023) : phase_limit[p];
            configure(phase_count[p], limit_value);
            steady_sender = (p % 3 == 1);
            n = sb.active_vertices();
            done_items = 0;
            while (done_items < RANDOM_ITEMS / PHASES)
            begin
                // Now and then hold the sender until the block has caught up.
                if ($urandom_range(0, 24) == 0)
                    drain();
                if ($urandom_range(0, 9) < 6)
                begin
                    if ($urandom_range(0, 6) == 0)
                        src = $urandom_range(0, 15);
                    else
                        src = $urandom_range(0, n - 1);
                    if (src < n)
                    begin
                        fill_block(n);
                        done_items++;
                    end
                    send_run(src);
                end
                else
                begin
                    if ($urandom_range(0, 9) < 7)
                        send_load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  pick_weight());
                    else
                        send_load($urandom_range(0, 15), $urandom_range(0, 15),
                                  pick_weight());
                    done_items++;
                end
            end
        end

        // Drop start, wait for the last reports, then watch for strays.
        drain();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
